[design/mdr_pkg.sv]
// Shared types and constants of the diversity re-ranker.
`timescale 1ns / 1ps
package mdr_pkg;

   localparam int POOL_DEPTH_DEF = 64;
   localparam int EMB_DIM_DEF    = 32;
   localparam int MAX_TOP_K_DEF  = 16;

   localparam logic [15:0] LAMBDA_RESET = 16'd22938;
   localparam logic [15:0] LAMBDA_ONE   = 16'd32768;
   localparam logic [4:0]  TOP_K_RESET  = 5'd8;
   localparam logic [9:0]  PENALTY_ONE  = 10'd246;
   localparam logic [9:0]  PENALTY_TWO  = 10'd492;
   localparam logic [1:0]  REPS_CAP     = 2'd2;

   localparam int CSR_AW = 3;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_ELEMENT = 2'd1;
   localparam logic [1:0] KIND_RUN     = 2'd2;

   localparam logic REG_LAMBDA = 1'b0;
   localparam logic REG_TOP_K  = 1'b1;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_REMOVE,
      CELL_ROTATE,
      CELL_SET_LEN
   } cell_op_type;

   // static part of a pool entry
   typedef struct packed {
      logic [15:0] rel;
      logic [16:0] author;    // bit 16 set when the author is known
      logic [15:0] arrival;
      logic        has_emb;
   } cell_meta_type;

   // per-run selection state of a pool entry
   typedef struct packed {
      logic        sel;
      logic [1:0]  reps;
      logic [14:0] maxsim;
   } cell_dyn_type;

   typedef struct packed {
      cell_op_type   op;
      cell_meta_type meta;
   } cell_cmd_type;

   typedef struct packed {
      logic        done;
      logic [14:0] sim;
   } dot_res_type;

endpackage

[design/mdr_if.sv]
// Request and response channel interfaces of the diversity re-ranker.
`timescale 1ns / 1ps
interface mdr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] relevance;
   logic [15:0] author_id;
   logic        has_author;
   logic        has_embedding;
   logic [15:0] embed_value;

   modport source (output valid, kind, relevance, author_id, has_author, has_embedding,
                   embed_value, input ready);
   modport sink   (input valid, kind, relevance, author_id, has_author, has_embedding,
                   embed_value, output ready);
endinterface

interface mdr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] arrival_index;
   logic [15:0] selected_relevance;
   logic        last;

   modport source (output valid, arrival_index, selected_relevance, last, input ready);
   modport sink   (input valid, arrival_index, selected_relevance, last, output ready);
endinterface

[design/mdr_cell.sv]
// One pool cell: holds a candidate entry and passes it to its neighbour.
`timescale 1ns / 1ps
module mdr_cell #(
   parameter int POOL_DEPTH = mdr_pkg::POOL_DEPTH_DEF,
   parameter int EMB_DIM    = mdr_pkg::EMB_DIM_DEF,
   parameter int CELL_INDEX = 0
) (
   input  logic                              clock,
   input  mdr_pkg::cell_cmd_type             cmd,
   input  logic [$clog2(POOL_DEPTH)-1:0]     cmd_idx,
   input  logic [$clog2(POOL_DEPTH)-1:0]     cmd_tail,
   input  logic [$clog2(POOL_DEPTH)-1:0]     ins_slot,
   input  logic [$clog2(EMB_DIM+1)-1:0]      cmd_len,
   input  mdr_pkg::cell_meta_type            next_meta,
   input  mdr_pkg::cell_dyn_type             next_dyn,
   input  logic [$clog2(POOL_DEPTH)-1:0]     next_slot,
   input  logic [$clog2(EMB_DIM+1)-1:0]      next_len,
   output mdr_pkg::cell_meta_type            meta_ff,
   output mdr_pkg::cell_dyn_type             dyn_ff,
   output logic [$clog2(POOL_DEPTH)-1:0]     slot_ff,
   output logic [$clog2(EMB_DIM+1)-1:0]      len_ff
);
   localparam int IW = $clog2(POOL_DEPTH);
   localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         mdr_pkg::CELL_HOLD: begin
         end
         mdr_pkg::CELL_APPEND: begin
            if (cmd_idx == MY_IDX) begin
               meta_ff <= cmd.meta;
               dyn_ff  <= '0;
               slot_ff <= ins_slot;
               len_ff  <= '0;
            end
         end
         mdr_pkg::CELL_REMOVE: begin
            // entries above the evicted one close the gap, the newcomer lands at the tail
            if (MY_IDX == cmd_tail) begin
               meta_ff <= cmd.meta;
               dyn_ff  <= '0;
               slot_ff <= ins_slot;
               len_ff  <= '0;
            end else if (MY_IDX >= cmd_idx && MY_IDX < cmd_tail) begin
               meta_ff <= next_meta;
               dyn_ff  <= next_dyn;
               slot_ff <= next_slot;
               len_ff  <= next_len;
            end
         end
         mdr_pkg::CELL_ROTATE: begin
            meta_ff <= next_meta;
            dyn_ff  <= next_dyn;
            slot_ff <= next_slot;
            len_ff  <= next_len;
         end
         mdr_pkg::CELL_SET_LEN: begin
            if (cmd_idx == MY_IDX) begin
               len_ff <= cmd_len;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[design/mdr_dot_unit.sv]
// Embedding store and serial dot product / similarity unit.
`timescale 1ns / 1ps
module mdr_dot_unit #(
   parameter int POOL_DEPTH = mdr_pkg::POOL_DEPTH_DEF,
   parameter int EMB_DIM    = mdr_pkg::EMB_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [$clog2(POOL_DEPTH)-1:0]   wr_slot,
   input  logic [$clog2(EMB_DIM)-1:0]      wr_elem,
   input  logic [15:0]                     wr_data,
   input  logic                            start,
   input  logic [$clog2(POOL_DEPTH)-1:0]   a_slot,
   input  logic [$clog2(EMB_DIM+1)-1:0]    a_len,
   input  logic [$clog2(POOL_DEPTH)-1:0]   b_slot,
   input  logic [$clog2(EMB_DIM+1)-1:0]    b_len,
   output mdr_pkg::dot_res_type            res
);
   localparam int PW    = $clog2(POOL_DEPTH);
   localparam int LW    = $clog2(EMB_DIM+1);
   localparam int DEPTH = POOL_DEPTH * EMB_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int ACC_W = 32 + LW;

   logic [15:0] mem [DEPTH];

   logic                    busy_ff;
   logic [LW-1:0]           issue_ff;
   logic [PW-1:0]           a_slot_ff, b_slot_ff;
   logic [LW-1:0]           a_len_ff, b_len_ff;
   logic                    vld1_ff, vld2_ff;
   logic                    mask_a_ff, mask_b_ff;
   logic [15:0]             rda_ff, rdb_ff;
   logic signed [31:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic                    issuing;
   logic [AW-1:0]           raddr_a, raddr_b, waddr;
   logic signed [15:0]      xa, xb;
   logic signed [31:0]      prod_in;

   assign issuing = busy_ff && (issue_ff != LW'(EMB_DIM));
   assign raddr_a = AW'(a_slot_ff) * AW'(EMB_DIM) + AW'(issue_ff);
   assign raddr_b = AW'(b_slot_ff) * AW'(EMB_DIM) + AW'(issue_ff);
   assign waddr   = AW'(wr_slot) * AW'(EMB_DIM) + AW'(wr_elem);

   // elements past the loaded length read as zero
   assign xa      = mask_a_ff ? $signed(rda_ff) : 16'sd0;
   assign xb      = mask_b_ff ? $signed(rdb_ff) : 16'sd0;
   assign prod_in = xa * xb;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wr_data;
      end
      rda_ff <= mem[raddr_a];
      rdb_ff <= mem[raddr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= issuing;
         vld2_ff <= vld1_ff;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (res.done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         issue_ff  <= '0;
         a_slot_ff <= a_slot;
         b_slot_ff <= b_slot;
         a_len_ff  <= a_len;
         b_len_ff  <= b_len;
         acc_ff    <= '0;
      end else begin
         if (issuing) begin
            issue_ff <= issue_ff + 1'b1;
         end
         if (vld2_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
      mask_a_ff <= issue_ff < a_len_ff;
      mask_b_ff <= issue_ff < b_len_ff;
      prod_ff   <= prod_in;
   end

   // similarity: dot >> 16, zero when not positive, saturated to 15 bits
   always_comb begin
      res.done = busy_ff && !issuing && !vld1_ff && !vld2_ff;
      if (acc_ff <= 0) begin
         res.sim = '0;
      end else if (acc_ff[ACC_W-1:31] != '0) begin
         res.sim = '1;
      end else begin
         res.sim = acc_ff[30:16];
      end
   end

endmodule

[design/mmr_diversity_rerank_core.sv]
// Top level of the diversity re-ranker: control, pool cell chain and configuration port.
`timescale 1ns / 1ps
// The candidate pool is a ring of POOL_DEPTH cells that is inspected at cell 0 while it
// rotates; embeddings sit in a memory read by a serial dot product unit.
// A header is appended while the pool has room; when it is full, a rotation of the whole
// pool finds the least relevant entry. An embedding element is written to the memory.
// A run does, for each selection step, a scoring rotation of the pool, the response
// transaction, then (except after the last step) an update rotation of the pool with a
// dot product unit pass for every other unselected entry with an embedding, when the
// selected entry has one too. A run on an empty pool sends no response.
module mmr_diversity_rerank_core #(
   parameter int POOL_DEPTH = mdr_pkg::POOL_DEPTH_DEF,
   parameter int EMB_DIM    = mdr_pkg::EMB_DIM_DEF,
   parameter int MAX_TOP_K  = mdr_pkg::MAX_TOP_K_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   mdr_req_if.sink                    req_ch,
   mdr_rsp_if.source                  rsp_ch,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [mdr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   localparam int IW  = $clog2(POOL_DEPTH);
   localparam int KCW = $clog2(POOL_DEPTH+1);
   localparam int LW  = $clog2(EMB_DIM+1);
   localparam int DW  = $clog2(EMB_DIM);
   localparam int TKW = $clog2(MAX_TOP_K+1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VSCAN,
      ST_VDECIDE,
      ST_SCORE,
      ST_SCORE_CMP,
      ST_EMIT,
      ST_UPDATE,
      ST_DOT
   } state_type;

   state_type              state_ff;
   logic [15:0]            lambda_ff;
   logic [4:0]             top_k_ff;
   logic [KCW-1:0]         kept_ff;
   logic [15:0]            arr_cnt_ff;
   logic [LW-1:0]          elem_cnt_ff;
   logic                   fill_active_ff;
   logic [IW-1:0]          fill_pos_ff;
   logic [IW-1:0]          fill_slot_ff;
   logic [IW-1:0]          pos_ff;
   mdr_pkg::cell_meta_type hdr_ff;
   logic [15:0]            min_rel_ff;
   logic [IW-1:0]          vic_pos_ff;
   logic [IW-1:0]          vic_slot_ff;
   logic [TKW-1:0]         n_ff;
   logic [TKW-1:0]         k_ff;
   logic                   best_vld_ff;
   logic signed [19:0]     best_score_ff;
   logic [IW-1:0]          best_pos_ff;
   mdr_pkg::cell_meta_type best_meta_ff;
   logic [IW-1:0]          best_slot_ff;
   logic [LW-1:0]          best_len_ff;
   logic signed [32:0]     p1_ff;
   logic [30:0]            p2_ff;

   mdr_pkg::cell_meta_type meta_w [POOL_DEPTH];
   mdr_pkg::cell_dyn_type  dyn_w  [POOL_DEPTH];
   logic [IW-1:0]          slot_w [POOL_DEPTH];
   logic [LW-1:0]          len_w  [POOL_DEPTH];

   mdr_pkg::cell_cmd_type  cmd;
   logic [IW-1:0]          cmd_idx, cmd_tail, ins_slot;
   logic [LW-1:0]          cmd_len;
   mdr_pkg::cell_dyn_type  rot_dyn;
   mdr_pkg::cell_meta_type req_meta;
   mdr_pkg::dot_res_type   dot_res;
   logic                   dot_start;

   logic                   req_acc, csr_wr, elem_ok, last_pos, cand, at_best, need_dot;
   logic                   take_hdr, last_sel;
   logic [TKW-1:0]         eff_k, n_calc;
   logic [TKW+1:0]         lim4;
   logic [KCW-1:0]         limit;
   logic [15:0]            lam_eff, one_m;
   logic signed [16:0]     lam_s;
   logic signed [32:0]     p1_in;
   logic [30:0]            p2_in;
   logic signed [33:0]     diff;
   logic [9:0]             pen;
   logic signed [19:0]     score;
   logic [1:0]             reps_next;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      unique case (csr_paddr[2])
         mdr_pkg::REG_LAMBDA: csr_prdata = {16'd0, lambda_ff};
         mdr_pkg::REG_TOP_K:  csr_prdata = {27'd0, top_k_ff};
      endcase
   end

   // ---------------- derived values ----------------
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign req_meta.rel     = req_ch.relevance;
   assign req_meta.author  = req_ch.has_author ? {1'b1, req_ch.author_id} : 17'd0;
   assign req_meta.arrival = arr_cnt_ff;
   assign req_meta.has_emb = req_ch.has_embedding;

   assign eff_k  = (32'(top_k_ff) > MAX_TOP_K) ? TKW'(MAX_TOP_K) : TKW'(top_k_ff);
   assign lim4   = {eff_k, 2'b00};
   assign limit  = (32'(lim4) > POOL_DEPTH) ? KCW'(POOL_DEPTH) : KCW'(lim4);
   assign n_calc = (32'(eff_k) > 32'(kept_ff)) ? TKW'(kept_ff) : eff_k;

   assign elem_ok  = fill_active_ff && (elem_cnt_ff < LW'(EMB_DIM));
   assign last_pos = (pos_ff == IW'(POOL_DEPTH - 1));
   assign cand     = (KCW'(pos_ff) < kept_ff) && !dyn_w[0].sel;
   assign at_best  = (pos_ff == best_pos_ff);
   assign need_dot = meta_w[0].has_emb && best_meta_ff.has_emb;
   assign take_hdr = $signed(hdr_ff.rel) > $signed(min_rel_ff);
   assign last_sel = (TKW'(k_ff + 1'b1) == n_ff);

   // score = floor((lambda*rel - (1-lambda)*maxsim) / 2^15) - author penalty
   assign lam_eff = (lambda_ff > mdr_pkg::LAMBDA_ONE) ? mdr_pkg::LAMBDA_ONE : lambda_ff;
   assign one_m   = mdr_pkg::LAMBDA_ONE - lam_eff;
   assign lam_s   = {1'b0, lam_eff};
   assign p1_in   = lam_s * $signed(meta_w[0].rel);
   assign p2_in   = 31'(one_m) * 31'(dyn_w[0].maxsim);
   assign diff    = 34'(p1_ff) - $signed({3'b000, p2_ff});
   always_comb begin
      unique case (dyn_w[0].reps)
         2'd0:    pen = 10'd0;
         2'd1:    pen = mdr_pkg::PENALTY_ONE;
         default: pen = mdr_pkg::PENALTY_TWO;
      endcase
   end
   assign score = {diff[33], diff[33:15]} - $signed({10'd0, pen});

   always_comb begin
      reps_next = dyn_w[0].reps;
      if (meta_w[0].author[16] && (meta_w[0].author == best_meta_ff.author)
          && (dyn_w[0].reps != mdr_pkg::REPS_CAP)) begin
         reps_next = dyn_w[0].reps + 1'b1;
      end
   end

   // ---------------- chain command ----------------
   always_comb begin
      cmd.op    = mdr_pkg::CELL_HOLD;
      cmd.meta  = req_meta;
      cmd_idx   = IW'(kept_ff);
      cmd_tail  = IW'(kept_ff - 1'b1);
      ins_slot  = IW'(kept_ff);
      cmd_len   = elem_cnt_ff + 1'b1;
      rot_dyn   = dyn_w[0];
      dot_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.kind == mdr_pkg::KIND_HEADER) begin
                  if (limit != '0 && kept_ff < limit) begin
                     cmd.op = mdr_pkg::CELL_APPEND;
                  end
               end else if (req_ch.kind == mdr_pkg::KIND_ELEMENT) begin
                  if (elem_ok) begin
                     cmd.op  = mdr_pkg::CELL_SET_LEN;
                     cmd_idx = fill_pos_ff;
                  end
               end
            end
         end
         ST_VSCAN: cmd.op = mdr_pkg::CELL_ROTATE;
         ST_VDECIDE: begin
            if (take_hdr) begin
               cmd.op   = mdr_pkg::CELL_REMOVE;
               cmd.meta = hdr_ff;
               cmd_idx  = vic_pos_ff;
               ins_slot = vic_slot_ff;
            end
         end
         ST_SCORE: begin
            if (!cand) begin
               cmd.op = mdr_pkg::CELL_ROTATE;
            end
         end
         ST_SCORE_CMP: cmd.op = mdr_pkg::CELL_ROTATE;
         ST_EMIT: begin
         end
         ST_UPDATE: begin
            if (!cand) begin
               cmd.op = mdr_pkg::CELL_ROTATE;
            end else if (at_best) begin
               cmd.op      = mdr_pkg::CELL_ROTATE;
               rot_dyn.sel = 1'b1;
            end else if (need_dot) begin
               dot_start = 1'b1;
            end else begin
               cmd.op       = mdr_pkg::CELL_ROTATE;
               rot_dyn.reps = reps_next;
            end
         end
         ST_DOT: begin
            if (dot_res.done) begin
               cmd.op       = mdr_pkg::CELL_ROTATE;
               rot_dyn.reps = reps_next;
               if (dot_res.sim > dyn_w[0].maxsim) begin
                  rot_dyn.maxsim = dot_res.sim;
               end
            end
         end
      endcase
   end

   // ---------------- cell chain ----------------
   for (genvar j = 0; j < POOL_DEPTH; j++) begin : g_cell
      if (j == POOL_DEPTH - 1) begin : g_end
         mdr_cell #(
            .POOL_DEPTH (POOL_DEPTH),
            .EMB_DIM    (EMB_DIM),
            .CELL_INDEX (j)
         ) u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .cmd_idx   (cmd_idx),
            .cmd_tail  (cmd_tail),
            .ins_slot  (ins_slot),
            .cmd_len   (cmd_len),
            .next_meta (meta_w[0]),
            .next_dyn  (rot_dyn),
            .next_slot (slot_w[0]),
            .next_len  (len_w[0]),
            .meta_ff   (meta_w[j]),
            .dyn_ff    (dyn_w[j]),
            .slot_ff   (slot_w[j]),
            .len_ff    (len_w[j])
         );
      end else begin : g_mid
         mdr_cell #(
            .POOL_DEPTH (POOL_DEPTH),
            .EMB_DIM    (EMB_DIM),
            .CELL_INDEX (j)
         ) u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .cmd_idx   (cmd_idx),
            .cmd_tail  (cmd_tail),
            .ins_slot  (ins_slot),
            .cmd_len   (cmd_len),
            .next_meta (meta_w[j+1]),
            .next_dyn  (dyn_w[j+1]),
            .next_slot (slot_w[j+1]),
            .next_len  (len_w[j+1]),
            .meta_ff   (meta_w[j]),
            .dyn_ff    (dyn_w[j]),
            .slot_ff   (slot_w[j]),
            .len_ff    (len_w[j])
         );
      end
   end

   mdr_dot_unit #(
      .POOL_DEPTH (POOL_DEPTH),
      .EMB_DIM    (EMB_DIM)
   ) u_dot (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_acc && req_ch.kind == mdr_pkg::KIND_ELEMENT && elem_ok),
      .wr_slot (fill_slot_ff),
      .wr_elem (elem_cnt_ff[DW-1:0]),
      .wr_data (req_ch.embed_value),
      .start   (dot_start),
      .a_slot  (slot_w[0]),
      .a_len   (len_w[0]),
      .b_slot  (best_slot_ff),
      .b_len   (best_len_ff),
      .res     (dot_res)
   );

   // ---------------- response ----------------
   assign rsp_ch.valid              = (state_ff == ST_EMIT);
   assign rsp_ch.arrival_index      = best_meta_ff.arrival;
   assign rsp_ch.selected_relevance = best_meta_ff.rel;
   assign rsp_ch.last               = last_sel;

   // ---------------- control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         lambda_ff      <= mdr_pkg::LAMBDA_RESET;
         top_k_ff       <= mdr_pkg::TOP_K_RESET;
         kept_ff        <= '0;
         arr_cnt_ff     <= '0;
         elem_cnt_ff    <= '0;
         fill_active_ff <= 1'b0;
         pos_ff         <= '0;
         best_vld_ff    <= 1'b0;
         k_ff           <= '0;
         n_ff           <= '0;
      end else begin
         if (csr_wr) begin
            unique case (csr_paddr[2])
               mdr_pkg::REG_LAMBDA: lambda_ff <= csr_pwdata[15:0];
               mdr_pkg::REG_TOP_K:  top_k_ff  <= csr_pwdata[4:0];
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_ch.kind == mdr_pkg::KIND_HEADER) begin
                     arr_cnt_ff     <= arr_cnt_ff + 1'b1;
                     fill_active_ff <= 1'b0;
                     elem_cnt_ff    <= '0;
                     if (limit != '0) begin
                        if (kept_ff < limit) begin
                           kept_ff        <= kept_ff + 1'b1;
                           fill_active_ff <= req_ch.has_embedding;
                           fill_pos_ff    <= IW'(kept_ff);
                           fill_slot_ff   <= IW'(kept_ff);
                        end else begin
                           hdr_ff   <= req_meta;
                           pos_ff   <= '0;
                           state_ff <= ST_VSCAN;
                        end
                     end
                  end else if (req_ch.kind == mdr_pkg::KIND_ELEMENT) begin
                     if (elem_ok) begin
                        elem_cnt_ff <= elem_cnt_ff + 1'b1;
                        if (cmd_len == LW'(EMB_DIM)) begin
                           fill_active_ff <= 1'b0;
                        end
                     end
                  end else if (req_ch.kind == mdr_pkg::KIND_RUN) begin
                     if (n_calc == '0) begin
                        kept_ff        <= '0;
                        arr_cnt_ff     <= '0;
                        elem_cnt_ff    <= '0;
                        fill_active_ff <= 1'b0;
                     end else begin
                        n_ff        <= n_calc;
                        k_ff        <= '0;
                        pos_ff      <= '0;
                        best_vld_ff <= 1'b0;
                        state_ff    <= ST_SCORE;
                     end
                  end
               end
            end
            ST_VSCAN: begin
               // last of the least relevant entries is the one to evict
               if (KCW'(pos_ff) < kept_ff
                   && (pos_ff == '0 || $signed(meta_w[0].rel) <= $signed(min_rel_ff))) begin
                  min_rel_ff  <= meta_w[0].rel;
                  vic_pos_ff  <= pos_ff;
                  vic_slot_ff <= slot_w[0];
               end
               pos_ff <= pos_ff + 1'b1;
               if (last_pos) begin
                  pos_ff   <= '0;
                  state_ff <= ST_VDECIDE;
               end
            end
            ST_VDECIDE: begin
               if (take_hdr) begin
                  fill_active_ff <= hdr_ff.has_emb;
                  fill_pos_ff    <= IW'(kept_ff - 1'b1);
                  fill_slot_ff   <= vic_slot_ff;
               end
               state_ff <= ST_IDLE;
            end
            ST_SCORE: begin
               if (cand) begin
                  p1_ff    <= p1_in;
                  p2_ff    <= p2_in;
                  state_ff <= ST_SCORE_CMP;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
                  if (last_pos) begin
                     pos_ff   <= '0;
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_SCORE_CMP: begin
               if (!best_vld_ff || score > best_score_ff) begin
                  best_vld_ff   <= 1'b1;
                  best_score_ff <= score;
                  best_pos_ff   <= pos_ff;
                  best_meta_ff  <= meta_w[0];
                  best_slot_ff  <= slot_w[0];
                  best_len_ff   <= len_w[0];
               end
               pos_ff   <= pos_ff + 1'b1;
               state_ff <= ST_SCORE;
               if (last_pos) begin
                  pos_ff   <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_ch.ready) begin
                  if (last_sel) begin
                     kept_ff        <= '0;
                     arr_cnt_ff     <= '0;
                     elem_cnt_ff    <= '0;
                     fill_active_ff <= 1'b0;
                     state_ff       <= ST_IDLE;
                  end else begin
                     pos_ff   <= '0;
                     state_ff <= ST_UPDATE;
                  end
               end
            end
            ST_UPDATE: begin
               if (cand && !at_best && need_dot) begin
                  state_ff <= ST_DOT;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
                  if (last_pos) begin
                     pos_ff      <= '0;
                     k_ff        <= k_ff + 1'b1;
                     best_vld_ff <= 1'b0;
                     state_ff    <= ST_SCORE;
                  end
               end
            end
            ST_DOT: begin
               if (dot_res.done) begin
                  pos_ff   <= pos_ff + 1'b1;
                  state_ff <= ST_UPDATE;
                  if (last_pos) begin
                     pos_ff      <= '0;
                     k_ff        <= k_ff + 1'b1;
                     best_vld_ff <= 1'b0;
                     state_ff    <= ST_SCORE;
                  end
               end
            end
         endcase
      end
   end

endmodule
